FILE: rtl/core/ptqs_pkg.sv
`default_nettype none
package ptqs_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 16;
   localparam logic [6:0] MAX_CONCURRENT_RESET = 7'd4;

   typedef enum logic [2:0] {
      OP_SUBMIT        = 3'd0,
      OP_UPDATE        = 3'd1,
      OP_CANCEL_ID     = 3'd2,
      OP_CANCEL_CAT    = 3'd3,
      OP_CANCEL_ABOVE  = 3'd4,
      OP_DISPATCH      = 3'd5,
      OP_COMPLETE      = 3'd6
   } op_type;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_FULL  = 3'd1,
      ST_EMPTY = 3'd2,
      ST_LIMIT = 3'd3,
      ST_NOKEY = 3'd4,
      ST_UNDER = 3'd5
   } status_type;

   typedef struct packed {
      logic [15:0] id;
      logic [7:0]  category;
      logic [2:0]  priority_val;
   } entry_type;

endpackage
`default_nettype wire

FILE: rtl/core/ptqs_store.sv
`default_nettype none
module ptqs_store #(
   parameter int DEPTH = 16,
   localparam int IDX_W = $clog2(DEPTH)
) (
   input  wire logic                clock,
   input  wire logic                wr_en,
   input  wire logic [IDX_W-1:0]    wr_addr,
   input  wire ptqs_pkg::entry_type wr_data,
   input  wire logic [IDX_W-1:0]    rd_addr,
   output ptqs_pkg::entry_type      rd_data_ff
);
   import ptqs_pkg::*;

   entry_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule
`default_nettype wire

FILE: rtl/core/priority_task_queue_scheduler.sv
`default_nettype none
// Pending tasks sit compacted in a single-port-write, registered-read table in
// arrival order. Submit and complete go straight from accept to output handoff;
// update and the three cancels walk the table once, with a read state and then
// an evaluate state per pending entry; dispatch walks it once to find the oldest
// most urgent entry and then shifts the younger entries down one by one, each
// through a read state and a write state, since the table read is registered.
// The block takes no new word until the current word's result is handed off.
module priority_task_queue_scheduler #(
   parameter int QUEUE_DEPTH = ptqs_pkg::QUEUE_DEPTH_DEFAULT,
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [2:0]       req_op,
   input  wire logic [15:0]      req_id_tag,
   input  wire logic [7:0]       req_category_tag,
   input  wire logic [2:0]       req_priority_req,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [2:0]            rsp_status,
   output logic [15:0]           rsp_task_id,
   output logic [CNT_W-1:0]      rsp_removed_count,
   output logic [CNT_W-1:0]      rsp_queue_count,
   output logic [6:0]            rsp_active_count,
   input  wire logic             csr_write_enable,
   input  wire logic [6:0]       csr_write_data
);
   import ptqs_pkg::*;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

   typedef enum logic [2:0] {S_IDLE, S_RD, S_EV, S_SHRD, S_SHEV, S_DONE} state_type;

   state_type        state_ff;
   logic [2:0]       op_ff;
   logic [15:0]      id_ff;
   logic [7:0]       cat_ff;
   logic [2:0]       pri_ff;
   logic [CNT_W-1:0] r_ff, w_ff, count_ff, removed_ff, best_ff;
   logic [2:0]       bestpri_ff;
   logic [15:0]      task_ff;
   logic [2:0]       status_ff;
   logic [6:0]       run_ff, max_ff;
   logic             rsp_valid_ff;
   logic [2:0]       rsp_status_ff;
   logic [15:0]      rsp_task_ff;
   logic [CNT_W-1:0] rsp_removed_ff, rsp_queue_ff;
   logic [6:0]       rsp_active_ff;

   entry_type        rd_data;
   entry_type        wr_data;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   logic             hit, accept;
   logic [CNT_W-1:0] r_nx;

   assign accept = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign r_nx = r_ff + CNT_ONE;
   assign rd_addr = (state_ff == S_SHRD) ? r_nx[IDX_W-1:0] : r_ff[IDX_W-1:0];

   always_comb begin
      case (op_ff)
         OP_CANCEL_ID:  hit = (rd_data.id == id_ff);
         OP_CANCEL_CAT: hit = (rd_data.category == cat_ff);
         default:       hit = (rd_data.priority_val > pri_ff);
      endcase
   end

   always_comb begin
      wr_en = 1'b0;
      wr_addr = r_ff[IDX_W-1:0];
      wr_data = rd_data;
      case (state_ff)
         S_IDLE: begin
            wr_addr = count_ff[IDX_W-1:0];
            wr_data = '{id: req_id_tag, category: req_category_tag,
                        priority_val: req_priority_req};
            wr_en = accept && (req_op == OP_SUBMIT) && (req_id_tag != '0)
                    && (count_ff != FULL_COUNT);
         end
         S_EV: begin
            if (op_ff == OP_UPDATE) begin
               wr_data.priority_val = pri_ff;
               wr_en = (rd_data.id == id_ff);
            end else if (op_ff inside {OP_CANCEL_ID, OP_CANCEL_CAT, OP_CANCEL_ABOVE}) begin
               wr_addr = w_ff[IDX_W-1:0];
               wr_en = !hit && (w_ff != r_ff);
            end
         end
         S_SHEV: wr_en = 1'b1;
         default: wr_en = 1'b0;
      endcase
   end

   ptqs_store #(.DEPTH(QUEUE_DEPTH)) u_store (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         run_ff <= '0;
         max_ff <= MAX_CONCURRENT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            max_ff <= csr_write_data;
         end
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  op_ff <= req_op;
                  id_ff <= req_id_tag;
                  cat_ff <= req_category_tag;
                  pri_ff <= req_priority_req;
                  status_ff <= ST_OK;
                  task_ff <= '0;
                  removed_ff <= '0;
                  r_ff <= '0;
                  w_ff <= '0;
                  best_ff <= '0;
                  state_ff <= S_DONE;
                  case (req_op)
                     OP_SUBMIT: begin
                        if (req_id_tag == '0) status_ff <= ST_NOKEY;
                        else if (count_ff == FULL_COUNT) status_ff <= ST_FULL;
                        else count_ff <= count_ff + CNT_ONE;
                     end
                     OP_UPDATE, OP_CANCEL_ID: begin
                        if (req_id_tag == '0) status_ff <= ST_NOKEY;
                        else if (count_ff != '0) state_ff <= S_RD;
                     end
                     OP_CANCEL_CAT: begin
                        if (req_category_tag == '0) status_ff <= ST_NOKEY;
                        else if (count_ff != '0) state_ff <= S_RD;
                     end
                     OP_CANCEL_ABOVE: begin
                        if (count_ff != '0) state_ff <= S_RD;
                     end
                     OP_DISPATCH: begin
                        if (count_ff == '0) status_ff <= ST_EMPTY;
                        else if (run_ff >= max_ff) status_ff <= ST_LIMIT;
                        else state_ff <= S_RD;
                     end
                     OP_COMPLETE: begin
                        if (run_ff == '0) status_ff <= ST_UNDER;
                        else run_ff <= run_ff - 7'd1;
                     end
                     default: status_ff <= ST_OK;
                  endcase
               end
            end
            S_RD: state_ff <= S_EV;
            S_EV: begin
               r_ff <= r_nx;
               state_ff <= (r_nx == count_ff) ? S_DONE : S_RD;
               case (op_ff)
                  OP_CANCEL_ID, OP_CANCEL_CAT, OP_CANCEL_ABOVE: begin
                     if (hit) removed_ff <= removed_ff + CNT_ONE;
                     else w_ff <= w_ff + CNT_ONE;
                     if (r_nx == count_ff) count_ff <= hit ? w_ff : w_ff + CNT_ONE;
                  end
                  OP_DISPATCH: begin
                     if (r_ff == '0 || rd_data.priority_val < bestpri_ff) begin
                        best_ff <= r_ff;
                        bestpri_ff <= rd_data.priority_val;
                        task_ff <= rd_data.id;
                     end
                     if (r_nx == count_ff) begin
                        if (r_ff == '0 || rd_data.priority_val < bestpri_ff) begin
                           count_ff <= count_ff - CNT_ONE;
                           run_ff <= run_ff + 7'd1;
                        end else begin
                           r_ff <= best_ff;
                           if (best_ff + CNT_ONE == count_ff) begin
                              count_ff <= count_ff - CNT_ONE;
                              run_ff <= run_ff + 7'd1;
                           end else begin
                              state_ff <= S_SHRD;
                           end
                        end
                     end
                  end
                  default: r_ff <= r_nx;
               endcase
            end
            S_SHRD: state_ff <= S_SHEV;
            S_SHEV: begin
               r_ff <= r_nx;
               if (r_nx + CNT_ONE == count_ff) begin
                  count_ff <= count_ff - CNT_ONE;
                  run_ff <= run_ff + 7'd1;
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_SHRD;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_status_ff <= status_ff;
                  rsp_task_ff <= task_ff;
                  rsp_removed_ff <= removed_ff;
                  rsp_queue_ff <= count_ff;
                  rsp_active_ff <= run_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_task_id = rsp_task_ff;
   assign rsp_removed_count = rsp_removed_ff;
   assign rsp_queue_count = rsp_queue_ff;
   assign rsp_active_count = rsp_active_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT) else $error("pending count exceeds depth");
   a_write_behind_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EV) |-> (w_ff <= r_ff)) else $error("compaction write ahead of read");
   a_task_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_task_id != '0) |-> (rsp_status == ST_OK))
      else $error("task id on failed operation");
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_EMPTY) |-> (rsp_queue_count == '0))
      else $error("empty status with pending entries");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/priority_task_queue_scheduler_tb.sv
module priority_task_queue_scheduler_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ptqs_pkg::*;

   localparam int DEPTH = 16;
   localparam int CYCLE_LIMIT = 2000000;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] task_id;
      logic [4:0]  removed_count;
      logic [4:0]  queue_count;
      logic [6:0]  active_count;
   } outcome_type;

   class sched_scoreboard;
      logic [15:0] ids[DEPTH];
      logic [7:0]  cats[DEPTH];
      logic [2:0]  pris[DEPTH];
      int          pending;
      int          running;
      int          limit_cfg;
      outcome_type awaited[$];
      int          mismatches;

      function void clear();
         pending = 0;
         running = 0;
         limit_cfg = MAX_CONCURRENT_RESET;
         awaited.delete();
         mismatches = 0;
      endfunction

      function int purge(int mode, logic [15:0] key);
         int w;
         int removed;
         logic hit;
         w = 0;
         removed = 0;
         for (int r = 0; r < pending; r++) begin
            if (mode == 0) hit = ids[r] == key;
            else if (mode == 1) hit = cats[r] == key[7:0];
            else hit = pris[r] > key[2:0];
            if (hit) begin
               removed++;
            end else begin
               ids[w] = ids[r];
               cats[w] = cats[r];
               pris[w] = pris[r];
               w++;
            end
         end
         pending = w;
         return removed;
      endfunction

      function void note_word(logic [2:0] op, logic [15:0] id, logic [7:0] cat,
                              logic [2:0] pri);
         outcome_type o;
         int best;
         o.status = ST_OK;
         o.task_id = '0;
         o.removed_count = '0;
         case (op)
            OP_SUBMIT: begin
               if (id == 0) o.status = ST_NOKEY;
               else if (pending >= DEPTH) o.status = ST_FULL;
               else begin
                  ids[pending] = id;
                  cats[pending] = cat;
                  pris[pending] = pri;
                  pending++;
               end
            end
            OP_UPDATE: begin
               if (id == 0) o.status = ST_NOKEY;
               else for (int i = 0; i < pending; i++) if (ids[i] == id) pris[i] = pri;
            end
            OP_CANCEL_ID: begin
               if (id == 0) o.status = ST_NOKEY;
               else o.removed_count = 5'(purge(0, id));
            end
            OP_CANCEL_CAT: begin
               if (cat == 0) o.status = ST_NOKEY;
               else o.removed_count = 5'(purge(1, {8'd0, cat}));
            end
            OP_CANCEL_ABOVE: o.removed_count = 5'(purge(2, {13'd0, pri}));
            OP_DISPATCH: begin
               if (pending == 0) o.status = ST_EMPTY;
               else if (running >= limit_cfg) o.status = ST_LIMIT;
               else begin
                  best = 0;
                  for (int i = 1; i < pending; i++) if (pris[i] < pris[best]) best = i;
                  o.task_id = ids[best];
                  for (int i = best; i + 1 < pending; i++) begin
                     ids[i] = ids[i + 1];
                     cats[i] = cats[i + 1];
                     pris[i] = pris[i + 1];
                  end
                  pending--;
                  running++;
               end
            end
            OP_COMPLETE: begin
               if (running == 0) o.status = ST_UNDER;
               else running--;
            end
            default: ;
         endcase
         o.queue_count = 5'(pending);
         o.active_count = 7'(running);
         awaited.insert(awaited.size(), o);
      endfunction

      function void check_result(outcome_type got);
         outcome_type want;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word status=%0d", got.status);
            return;
         end
         want = awaited.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch exp %0d %0h %0d %0d %0d got %0d %0h %0d %0d %0d",
                        want.status, want.task_id, want.removed_count, want.queue_count,
                        want.active_count, got.status, got.task_id, got.removed_count,
                        got.queue_count, got.active_count);
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [2:0]  req_op = '0;
   logic [15:0] req_id_tag = '0;
   logic [7:0]  req_category_tag = '0;
   logic [2:0]  req_priority_req = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_task_id;
   logic [4:0]  rsp_removed_count;
   logic [4:0]  rsp_queue_count;
   logic [6:0]  rsp_active_count;
   logic        csr_write_enable = 0;
   logic [6:0]  csr_write_data = '0;

   sched_scoreboard board;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_len = 0;
   int hold_cycles = 0;
   logic hold_taken = 0;
   int cycles = 0;
   logic [15:0] id_pool[8];

   priority_task_queue_scheduler dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("priority_task_queue_scheduler_tb failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      outcome_type got;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got.status = rsp_status;
            got.task_id = rsp_task_id;
            got.removed_count = rsp_removed_count;
            got.queue_count = rsp_queue_count;
            got.active_count = rsp_active_count;
            board.check_result(got);
         end
         if (hold_len != 0 && !hold_taken) begin
            hold_taken <= 1;
            hold_cycles <= hold_len;
            rsp_ready <= 0;
         end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_ready <= 0;
         end else begin
            rsp_ready <= $urandom_range(99) >= recv_idle_pct;
         end
      end
   end

   task automatic send_word(logic [2:0] op, logic [15:0] id, logic [7:0] cat,
                            logic [2:0] pri);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_op <= op;
      req_id_tag <= id;
      req_category_tag <= cat;
      req_priority_req <= pri;
      do @(posedge clock); while (!req_ready);
      board.note_word(op, id, cat, pri);
   endtask

   task automatic write_limit(logic [6:0] value);
      req_valid <= 0;
      while (board.awaited.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      csr_write_enable <= 1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 0;
      board.limit_cfg = value;
   endtask

   task automatic random_word();
      int pick;
      logic [15:0] id;
      pick = $urandom_range(99);
      id = ($urandom_range(9) == 0) ? 16'($urandom) : id_pool[$urandom_range(7)];
      if ($urandom_range(30) == 0) id = 0;
      if (pick < 35)
         send_word(OP_SUBMIT, id, 8'($urandom_range(4)), 3'($urandom));
      else if (pick < 43) send_word(OP_UPDATE, id, 8'($urandom), 3'($urandom));
      else if (pick < 49) send_word(OP_CANCEL_ID, id, 8'($urandom), 3'($urandom));
      else if (pick < 53)
         send_word(OP_CANCEL_CAT, 16'($urandom), 8'($urandom_range(4)), 3'($urandom));
      else if (pick < 56)
         send_word(OP_CANCEL_ABOVE, 16'($urandom), 8'($urandom), 3'($urandom));
      else if (pick < 78) send_word(OP_DISPATCH, 16'($urandom), 8'($urandom), 3'($urandom));
      else if (pick < 98) send_word(OP_COMPLETE, 16'($urandom), 8'($urandom), 3'($urandom));
      else send_word(3'd7, 16'($urandom), 8'($urandom), 3'($urandom));
   endtask

   initial begin
      board = new();
      board.clear();
      send_idle_pct = 11;
      recv_idle_pct = 64;
      for (int i = 0; i < 8; i++) id_pool[i] = 16'($urandom_range(1, 65535));
      id_pool[0] = 16'hFFFF;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_word(OP_DISPATCH, 16'h1, 8'h1, 3'd0);
      send_word(OP_COMPLETE, 16'h0, 8'h0, 3'd0);
      send_word(OP_SUBMIT, 16'h0, 8'h5, 3'd1);
      send_word(OP_SUBMIT, 16'hFFFF, 8'hFF, 3'd7);
      send_word(OP_SUBMIT, 16'h0001, 8'h01, 3'd0);
      send_word(OP_SUBMIT, 16'h0002, 8'hFF, 3'd0);
      send_word(OP_UPDATE, 16'h0, 8'h0, 3'd0);
      send_word(OP_UPDATE, 16'h1234, 8'h0, 3'd0);
      send_word(OP_UPDATE, 16'hFFFF, 8'h0, 3'd5);
      send_word(OP_CANCEL_ID, 16'h0, 8'h0, 3'd0);
      send_word(OP_CANCEL_CAT, 16'h0, 8'h0, 3'd0);
      send_word(OP_DISPATCH, 16'h0, 8'h0, 3'd0);
      send_word(OP_CANCEL_ABOVE, 16'h0, 8'h0, 3'd4);
      send_word(3'd7, 16'hFFFF, 8'hFF, 3'd7);
      for (int i = 0; i < 17; i++) send_word(OP_SUBMIT, 16'(i + 3), 8'(i % 3 + 1), 3'(i));
      send_word(OP_CANCEL_CAT, 16'h0, 8'h02, 3'd0);
      send_word(OP_CANCEL_ID, 16'h0003, 8'h0, 3'd0);
      for (int i = 0; i < 5; i++) send_word(OP_DISPATCH, 16'h0, 8'h0, 3'd0);
      send_word(OP_CANCEL_ABOVE, 16'h0, 8'h0, 3'd0);

      write_limit(7'd0);
      send_word(OP_SUBMIT, 16'h00AA, 8'h1, 3'd2);
      send_word(OP_DISPATCH, 16'h0, 8'h0, 3'd0);
      write_limit(7'd64);
      for (int i = 0; i < 500; i++) random_word();
      send_idle_pct = 64;
      recv_idle_pct = 11;
      write_limit(7'd1);
      for (int i = 0; i < 400; i++) random_word();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_limit(7'd4);
      hold_len = 400;
      for (int i = 0; i < 400; i++) random_word();
      write_limit(7'd127);
      for (int i = 0; i < 400; i++) random_word();

      req_valid <= 0;
      while (board.awaited.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (board.mismatches == 0)
         $display("priority_task_queue_scheduler_tb passed");
      else
         $display("priority_task_queue_scheduler_tb failed");
      $finish;
   end
endmodule
